### src/tcles_pkg.sv
package tcles_pkg;

    localparam int FLOOR_COUNT = 8;
    localparam int MASK_W      = FLOOR_COUNT;
    localparam int POS_W       = $clog2(FLOOR_COUNT + 1);

    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        logic       mode;
        logic       car_one_press;
        logic [2:0] car_one_press_floor;
        logic       car_two_press;
        logic [2:0] car_two_press_floor;
        logic       hall_up_press;
        logic [2:0] hall_up_floor;
        logic       hall_down_press;
        logic [2:0] hall_down_floor;
    } req_t;

    typedef struct packed {
        logic [3:0] car_one_floor;
        logic [3:0] car_two_floor;
        logic [1:0] car_one_direction;
        logic [1:0] car_two_direction;
        logic [7:0] car_one_calls;
        logic [7:0] car_two_calls;
        logic [7:0] up_calls;
        logic [7:0] down_calls;
    } rsp_t;

    typedef struct packed {
        pos_t  pos_one;
        pos_t  pos_two;
        dir_t  dir_one;
        dir_t  dir_two;
        mask_t cab_one;
        mask_t cab_two;
        mask_t up;
        mask_t down;
    } state_t;

    typedef struct packed {
        pos_t pos;
        dir_t dir;
    } move_t;

    function automatic logic any_above(mask_t m, pos_t p);
        return (m >> p) != '0;
    endfunction

    function automatic mask_t floor_bit(pos_t p);
        return mask_t'(1) << (p - pos_t'(1));
    endfunction

    function automatic logic any_below(mask_t m, pos_t p);
        return (m & (floor_bit(p) - mask_t'(1))) != '0;
    endfunction

    function automatic pos_t go_up(pos_t p);
        return (p < pos_t'(FLOOR_COUNT)) ? p + pos_t'(1) : p;
    endfunction

    function automatic pos_t go_down(pos_t p);
        return (p > pos_t'(1)) ? p - pos_t'(1) : p;
    endfunction

    function automatic mask_t add_call(mask_t m, logic on, logic [2:0] idx);
        if (on && (int'(idx) < FLOOR_COUNT)) begin
            return m | (mask_t'(1) << idx);
        end
        return m;
    endfunction

    // One LOOK decision for a car: keep going while work lies ahead, turn, or idle.
    function automatic move_t look_move(mask_t cab, mask_t u, mask_t w, pos_t p, dir_t d);
        move_t r;
        logic  ab_all;
        logic  be_all;
        r.pos  = p;
        r.dir  = d;
        ab_all = any_above(cab, p) || any_above(u, p) || any_above(w, p);
        be_all = any_below(cab, p) || any_below(u, p) || any_below(w, p);
        case (d)
            DIR_IDLE:
            begin
                if (any_above(cab, p)) begin
                    r.dir = DIR_UP;
                    r.pos = go_up(p);
                end else if (any_below(cab, p)) begin
                    r.dir = DIR_DOWN;
                    r.pos = go_down(p);
                end
            end
            DIR_UP:
            begin
                if (ab_all) begin
                    r.pos = go_up(p);
                end else if (be_all) begin
                    r.dir = DIR_DOWN;
                    r.pos = go_down(p);
                end else begin
                    r.dir = DIR_IDLE;
                end
            end
            default:
            begin
                if (be_all) begin
                    r.dir = DIR_DOWN;
                    r.pos = go_down(p);
                end else if (ab_all) begin
                    r.dir = DIR_UP;
                    r.pos = go_up(p);
                end else begin
                    r.dir = DIR_IDLE;
                end
            end
        endcase
        return r;
    endfunction

endpackage

### src/tcles_step.sv
module tcles_step (
    input  tcles_pkg::state_t cur,
    input  tcles_pkg::req_t   req,
    output tcles_pkg::state_t nxt
);
    import tcles_pkg::*;

    always_comb
    begin
        state_t s;
        move_t  m;
        mask_t  u;
        mask_t  w;
        mask_t  b;

        m      = '0;
        u      = '0;
        w      = '0;
        b      = '0;
        s      = cur;
        s.cab_one = add_call(cur.cab_one, req.car_one_press, req.car_one_press_floor);
        s.cab_two = add_call(cur.cab_two, req.car_two_press, req.car_two_press_floor);
        s.up      = add_call(cur.up, req.hall_up_press, req.hall_up_floor);
        s.down    = add_call(cur.down, req.hall_down_press, req.hall_down_floor);

        if (req.mode) begin
            m = look_move(s.cab_one, s.up, s.down, s.pos_one, s.dir_one);
            s.pos_one = m.pos;
            s.dir_one = m.dir;
            m = look_move(s.cab_two, s.up, s.down, s.pos_two, s.dir_two);
            s.pos_two = m.pos;
            s.dir_two = m.dir;

            // split idle cars over the pending hall calls
            u = s.up;
            w = s.down;
            if (s.dir_one == DIR_IDLE && s.dir_two == DIR_IDLE) begin
                if (s.pos_one > s.pos_two) begin
                    if (any_above(u, s.pos_one) || any_above(w, s.pos_one)) begin
                        s.dir_one = DIR_UP;
                        s.pos_one = go_up(s.pos_one);
                    end
                    if (any_below(u, s.pos_two) || any_below(w, s.pos_two)) begin
                        s.dir_two = DIR_DOWN;
                        s.pos_two = go_down(s.pos_two);
                    end
                    if (s.dir_one == DIR_IDLE && s.dir_two == DIR_IDLE
                        && (u != '0 || w != '0)) begin
                        s.pos_one = go_down(s.pos_one);
                        s.dir_one = DIR_DOWN;
                        s.pos_two = go_up(s.pos_two);
                        s.dir_two = DIR_UP;
                    end
                end else begin
                    if (any_above(u, s.pos_two) || any_above(w, s.pos_two)) begin
                        s.dir_two = DIR_UP;
                        s.pos_two = go_up(s.pos_two);
                    end
                    if (any_below(u, s.pos_one) || any_below(w, s.pos_one)) begin
                        s.dir_one = DIR_DOWN;
                        s.pos_one = go_down(s.pos_one);
                    end
                    if (s.dir_one == DIR_IDLE && s.dir_two == DIR_IDLE
                        && (u != '0 || w != '0)) begin
                        s.pos_one = go_up(s.pos_one);
                        s.dir_one = DIR_UP;
                        s.pos_two = go_down(s.pos_two);
                        s.dir_two = DIR_DOWN;
                    end
                end
            end else if (s.dir_one == DIR_IDLE) begin
                if (s.dir_two == DIR_UP) begin
                    if (any_below(u, s.pos_one)) begin
                        s.pos_one = go_down(s.pos_one);
                        s.dir_one = DIR_DOWN;
                    end
                end else if (any_above(w, s.pos_one)) begin
                    s.pos_one = go_up(s.pos_one);
                    s.dir_one = DIR_UP;
                end
            end else if (s.dir_two == DIR_IDLE) begin
                if (s.dir_one == DIR_UP) begin
                    if (any_below(u, s.pos_two)) begin
                        s.pos_two = go_down(s.pos_two);
                        s.dir_two = DIR_DOWN;
                    end
                end else if (any_above(w, s.pos_two)) begin
                    s.pos_two = go_up(s.pos_two);
                    s.dir_two = DIR_UP;
                end
            end

            // drop served calls, car one first
            b = floor_bit(s.pos_one);
            case (s.dir_one)
                DIR_IDLE:
                begin
                end
                DIR_UP:
                begin
                    s.up      = s.up & ~b;
                    s.cab_one = s.cab_one & ~b;
                    if (!any_above(s.cab_one, s.pos_one) && !any_above(s.up, s.pos_one)
                        && !any_above(s.down, s.pos_one)) begin
                        s.down = s.down & ~b;
                    end
                end
                default:
                begin
                    s.down    = s.down & ~b;
                    s.cab_one = s.cab_one & ~b;
                    if (!any_below(s.cab_one, s.pos_one) && !any_below(s.down, s.pos_one)
                        && !any_below(s.up, s.pos_one)) begin
                        s.up = s.up & ~b;
                    end
                end
            endcase

            b = floor_bit(s.pos_two);
            case (s.dir_two)
                DIR_IDLE:
                begin
                end
                DIR_UP:
                begin
                    s.up      = s.up & ~b;
                    s.cab_two = s.cab_two & ~b;
                    if (!any_above(s.cab_two, s.pos_two) && !any_above(s.up, s.pos_two)
                        && !any_above(s.down, s.pos_two)) begin
                        s.down = s.down & ~b;
                    end
                end
                default:
                begin
                    s.down    = s.down & ~b;
                    s.cab_two = s.cab_two & ~b;
                    if (!any_below(s.cab_two, s.pos_two) && !any_below(s.down, s.pos_two)
                        && !any_below(s.up, s.pos_two)) begin
                        s.up = s.up & ~b;
                    end
                end
            endcase
        end

        nxt = s;
    end

endmodule

### src/two_car_look_elevator_scheduler_unit.sv
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_stall  req_t: mode and four button presses
// rsp      out        rsp_valid/rsp_stall  rsp_t: floors, directions, call masks
//
// One word is taken per cycle while req_stall is low; its result appears on rsp in the cycle after acceptance.
// The scheduler step is one pass of logic from the state registers to the result register.
// Reset puts both cars idle at floor 1 with all call masks empty.
// req_stall is high only while a result is held and rsp_stall is high.
module two_car_look_elevator_scheduler_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  tcles_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output tcles_pkg::rsp_t rsp
);
    import tcles_pkg::*;

    state_t state_reg;
    state_t state_next;
    rsp_t   rsp_reg;
    logic   rsp_valid_reg;
    logic   accept;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    tcles_step u_step (
        .cur (state_reg),
        .req (req),
        .nxt (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.pos_one <= pos_t'(1);
            state_reg.pos_two <= pos_t'(1);
            state_reg.dir_one <= DIR_IDLE;
            state_reg.dir_two <= DIR_IDLE;
            state_reg.cab_one <= '0;
            state_reg.cab_two <= '0;
            state_reg.up      <= '0;
            state_reg.down    <= '0;
            rsp_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                state_reg     <= state_next;
                rsp_valid_reg <= 1'b1;
            end else if (!rsp_stall) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            rsp_reg.car_one_floor     <= 4'(state_next.pos_one);
            rsp_reg.car_two_floor     <= 4'(state_next.pos_two);
            rsp_reg.car_one_direction <= state_next.dir_one;
            rsp_reg.car_two_direction <= state_next.dir_two;
            rsp_reg.car_one_calls     <= 8'(state_next.cab_one);
            rsp_reg.car_two_calls     <= 8'(state_next.cab_two);
            rsp_reg.up_calls          <= 8'(state_next.up);
            rsp_reg.down_calls        <= 8'(state_next.down);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg))
        else $error("scheduler state changed without an accepted word");

    a_capture_only: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !req.mode |=> $stable(state_reg.pos_one) && $stable(state_reg.pos_two)
                                && $stable(state_reg.dir_one) && $stable(state_reg.dir_two))
        else $error("car moved on a capture-only word");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pos_one >= pos_t'(1) && state_reg.pos_one <= pos_t'(FLOOR_COUNT)
        && state_reg.pos_two >= pos_t'(1) && state_reg.pos_two <= pos_t'(FLOOR_COUNT))
        else $error("car floor out of range");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid && rsp.car_one_floor == 4'(state_reg.pos_one)
                   && rsp.up_calls == 8'(state_reg.up))
        else $error("result does not match updated state");

endmodule
